[src/motion_command_frame_crc16_top_macros.svh]
// assertion macros shared by the checker of the motion command framer
// depends on nothing; included by the checker file
`ifndef MOTION_COMMAND_FRAME_CRC16_TOP_MACROS_SVH
`define MOTION_COMMAND_FRAME_CRC16_TOP_MACROS_SVH

// same-cycle implication on clock, off while reset is high
`define MCFC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, off while reset is high
`define MCFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/mcfc_pkg.sv]
// shared types, constants and the crc table function of the motion command framer
// no dependencies
`timescale 1ns / 1ps

package mcfc_pkg;

   localparam int FRAME_BYTES = 26;
   localparam logic [4:0] LAST_POS = 5'(FRAME_BYTES - 1);
   localparam logic [4:0] CRC_FIRST_POS = 5'd1;
   localparam logic [4:0] CRC_LAST_POS = 5'(FRAME_BYTES - 3);
   localparam logic [15:0] CRC_SEED = 16'h2B3B;
   localparam logic [15:0] CRC_POLY = 16'h2333;

   localparam logic [7:0] START_BYTE_RESET = 8'h00;
   localparam logic [7:0] COMMAND_TYPE_RESET = 8'h00;
   localparam logic [7:0] NODE_ID_RESET = 8'h00;
   localparam logic [7:0] PAYLOAD_LENGTH_RESET = 8'd20;
   localparam logic [31:0] MOVE_ACCEL_RESET = 32'h3F00_0000;
   localparam logic [31:0] ROTATE_ACCEL_RESET = 32'h4234_0000;

   typedef enum logic [2:0] {
      CSR_START_BYTE = 3'd0,
      CSR_COMMAND_TYPE = 3'd1,
      CSR_NODE_ID = 3'd2,
      CSR_PAYLOAD_LENGTH = 3'd3,
      CSR_MOVE_ACCEL = 3'd4,
      CSR_ROTATE_ACCEL = 3'd5
   } csr_index_type;

   // word slots of the frame, selected by position bits [4:2]
   typedef enum logic [2:0] {
      SLOT_HEADER = 3'd0,
      SLOT_MOVE_ACCEL = 3'd1,
      SLOT_ROTATE_ACCEL = 3'd2,
      SLOT_SPEED = 3'd3,
      SLOT_HEADING = 3'd4,
      SLOT_TURN_RATE = 3'd5,
      SLOT_CHECKSUM = 3'd6
   } slot_type;

   typedef struct packed {
      logic [31:0] speed_bits;
      logic [31:0] heading_bits;
      logic [31:0] turn_rate_bits;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [4:0] byte_offset;
      logic last_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic at_last;
   } dp_status_type;

   // reflected crc table entry
   function automatic logic [15:0] crc_entry(input logic [7:0] idx);
      logic [15:0] c;
      c = {8'h00, idx};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[src/mcfc_ctrl.sv]
// controller state machine of the motion command framer
// depends on mcfc_pkg
`timescale 1ns / 1ps

module mcfc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  mcfc_pkg::dp_status_type status,
   output mcfc_pkg::dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic last_emit;

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      last_emit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SEND: begin
            cmd.emit = status.out_free;
            last_emit = status.out_free && status.at_last;
            req_ready = last_emit;
            if (last_emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // new transaction starts the next frame
      if (req_ready && req_valid) begin
         cmd.load = 1'b1;
         state_in = ST_SEND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/mcfc_datapath.sv]
// datapath of the motion command framer: registers, held words, byte select,
// running crc and output register; depends on mcfc_pkg
`timescale 1ns / 1ps

module mcfc_datapath (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_wdata,
   input  mcfc_pkg::req_payload_type req_payload,
   input  mcfc_pkg::dp_cmd_type cmd,
   output mcfc_pkg::dp_status_type status,
   input  logic rsp_ready,
   output logic rsp_valid,
   output mcfc_pkg::rsp_payload_type rsp_payload
);

   logic [7:0] start_byte_ff;
   logic [7:0] command_type_ff;
   logic [7:0] node_id_ff;
   logic [7:0] payload_length_ff;
   logic [31:0] move_accel_ff;
   logic [31:0] rotate_accel_ff;

   mcfc_pkg::req_payload_type held_ff;
   logic [4:0] pos_ff;
   logic [4:0] pos_in;
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   mcfc_pkg::rsp_payload_type rsp_ff;

   logic [31:0] word_sel;
   logic [7:0] cur_byte;
   logic in_crc;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= mcfc_pkg::START_BYTE_RESET;
         command_type_ff <= mcfc_pkg::COMMAND_TYPE_RESET;
         node_id_ff <= mcfc_pkg::NODE_ID_RESET;
         payload_length_ff <= mcfc_pkg::PAYLOAD_LENGTH_RESET;
         move_accel_ff <= mcfc_pkg::MOVE_ACCEL_RESET;
         rotate_accel_ff <= mcfc_pkg::ROTATE_ACCEL_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mcfc_pkg::CSR_START_BYTE:     start_byte_ff <= csr_wdata[7:0];
            mcfc_pkg::CSR_COMMAND_TYPE:   command_type_ff <= csr_wdata[7:0];
            mcfc_pkg::CSR_NODE_ID:        node_id_ff <= csr_wdata[7:0];
            mcfc_pkg::CSR_PAYLOAD_LENGTH: payload_length_ff <= csr_wdata[7:0];
            mcfc_pkg::CSR_MOVE_ACCEL:     move_accel_ff <= csr_wdata;
            mcfc_pkg::CSR_ROTATE_ACCEL:   rotate_accel_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // byte select
   always_comb begin
      unique case (pos_ff[4:2])
         mcfc_pkg::SLOT_HEADER:
            word_sel = {payload_length_ff, node_id_ff, command_type_ff, start_byte_ff};
         mcfc_pkg::SLOT_MOVE_ACCEL:   word_sel = move_accel_ff;
         mcfc_pkg::SLOT_ROTATE_ACCEL: word_sel = rotate_accel_ff;
         mcfc_pkg::SLOT_SPEED:        word_sel = held_ff.speed_bits;
         mcfc_pkg::SLOT_HEADING:      word_sel = held_ff.heading_bits;
         mcfc_pkg::SLOT_TURN_RATE:    word_sel = held_ff.turn_rate_bits;
         mcfc_pkg::SLOT_CHECKSUM:     word_sel = {16'h0000, crc_ff};
         default:                     word_sel = '0;
      endcase
      case (pos_ff[1:0])
         2'd0:    cur_byte = word_sel[7:0];
         2'd1:    cur_byte = word_sel[15:8];
         2'd2:    cur_byte = word_sel[23:16];
         default: cur_byte = word_sel[31:24];
      endcase
   end

   assign in_crc = (pos_ff >= mcfc_pkg::CRC_FIRST_POS) && (pos_ff <= mcfc_pkg::CRC_LAST_POS);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.at_last = (pos_ff == mcfc_pkg::LAST_POS);

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         pos_in = status.at_last ? 5'd0 : pos_ff + 5'd1;
         if (in_crc) begin
            crc_in = (crc_ff >> 8) ^ mcfc_pkg::crc_entry(crc_ff[7:0] ^ cur_byte);
         end
      end
      if (cmd.load) begin
         pos_in = 5'd0;
         crc_in = mcfc_pkg::CRC_SEED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 5'd0;
         crc_ff <= mcfc_pkg::CRC_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         held_ff <= req_payload;
      end
      if (cmd.emit) begin
         rsp_ff.frame_byte <= cur_byte;
         rsp_ff.byte_offset <= pos_ff;
         rsp_ff.last_byte <= status.at_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[src/motion_command_frame_crc16_top.sv]
// a request transaction loads the held words and the byte counter; then the output
// register takes one frame byte per cycle from the byte counter while it is free;
// the next command is taken in the cycle the last byte enters the output register
// reset: synchronous, active high; registers return to defaults, crc to 0x2B3B
// top level of the motion command framer; depends on mcfc_pkg, mcfc_ctrl, mcfc_datapath
`timescale 1ns / 1ps

module motion_command_frame_crc16_top (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_wdata,
   input  logic req_valid,
   output logic req_ready,
   input  mcfc_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output mcfc_pkg::rsp_payload_type rsp_payload
);

   mcfc_pkg::dp_cmd_type cmd;
   mcfc_pkg::dp_status_type status;

   mcfc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   mcfc_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_payload(req_payload),
      .cmd(cmd),
      .status(status),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload)
   );

endmodule

[src/mcfc_checker.sv]
// port-level checker of the motion command framer and its bind
// depends on mcfc_pkg and motion_command_frame_crc16_top_macros.svh
`timescale 1ns / 1ps
`include "motion_command_frame_crc16_top_macros.svh"

module mcfc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input mcfc_pkg::rsp_payload_type rsp_payload
);

   logic rsp_stall;
   logic rsp_mid;
   logic req_fire;
   logic last_ok;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_mid = rsp_valid && rsp_ready && !rsp_payload.last_byte;
   assign req_fire = req_valid && req_ready;
   assign last_ok = rsp_payload.last_byte == (rsp_payload.byte_offset == mcfc_pkg::LAST_POS);

   `MCFC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "payload not held")
   `MCFC_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready, "ready while framing")
   `MCFC_ASSERT_NEXT(a_no_gap, rsp_mid, rsp_valid, "gap inside frame")
   `MCFC_ASSERT_NOW(a_last_pos, rsp_valid, last_ok, "last byte flag mismatch")

endmodule

bind motion_command_frame_crc16_top mcfc_checker u_mcfc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_payload(rsp_payload)
);

[bench/tb.sv]
`timescale 1ns / 1ps
// testbench of the motion command framer: sends motion commands and register settings,
// predicts each 26-byte frame with its crc16 and checks every byte in order
// depends on mcfc_pkg and motion_command_frame_crc16_top

module tb;
   import mcfc_pkg::*;

   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam int MAX_REPORTS = 10;

   localparam logic [31:0] POS_INF = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF = 32'hFF80_0000;
   localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;
   localparam logic [31:0] NEG_ZERO = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] start_byte;
      logic [31:0] command_type;
      logic [31:0] node_id;
      logic [31:0] payload_length;
      logic [31:0] move_accel;
      logic [31:0] rotate_accel;
   } frame_setup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   // mirror of the register file
   logic [7:0] hdr_start = START_BYTE_RESET;
   logic [7:0] hdr_command = COMMAND_TYPE_RESET;
   logic [7:0] hdr_node = NODE_ID_RESET;
   logic [7:0] hdr_length = PAYLOAD_LENGTH_RESET;
   logic [31:0] word_move_accel = MOVE_ACCEL_RESET;
   logic [31:0] word_rotate_accel = ROTATE_ACCEL_RESET;

   rsp_payload_type pending_frame_bytes[$];
   rsp_payload_type due_byte;
   int fail_count = 0;
   int stall_left = 0;
   bit source_idle_on = 1'b1;
   bit sink_idle_on = 1'b1;

   motion_command_frame_crc16_top u_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // reflected crc16, one data bit per step
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] r;
      logic fb;
      r = crc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ data[k];
         r = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic predict_frame(input req_payload_type cmd);
      logic [7:0] frame_image [FRAME_BYTES];
      logic [15:0] crc;
      rsp_payload_type entry;
      frame_image[0] = hdr_start;
      frame_image[1] = hdr_command;
      frame_image[2] = hdr_node;
      frame_image[3] = hdr_length;
      for (int i = 0; i < 4; i++) begin
         frame_image[4 + i] = word_move_accel[8 * i +: 8];
         frame_image[8 + i] = word_rotate_accel[8 * i +: 8];
         frame_image[12 + i] = cmd.speed_bits[8 * i +: 8];
         frame_image[16 + i] = cmd.heading_bits[8 * i +: 8];
         frame_image[20 + i] = cmd.turn_rate_bits[8 * i +: 8];
      end
      crc = CRC_SEED;
      for (int i = int'(CRC_FIRST_POS); i <= int'(CRC_LAST_POS); i++) begin
         crc = crc16_step(crc, frame_image[i]);
      end
      frame_image[FRAME_BYTES - 2] = crc[7:0];
      frame_image[FRAME_BYTES - 1] = crc[15:8];
      for (int i = 0; i < FRAME_BYTES; i++) begin
         entry.frame_byte = frame_image[i];
         entry.byte_offset = 5'(i);
         entry.last_byte = (i == FRAME_BYTES - 1);
         pending_frame_bytes.push_back(entry);
      end
   endtask

   task automatic send_command(input req_payload_type cmd);
      req_payload <= cmd;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_frame(cmd);
      if (source_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      while (pending_frame_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_START_BYTE: hdr_start = data[7:0];
         CSR_COMMAND_TYPE: hdr_command = data[7:0];
         CSR_NODE_ID: hdr_node = data[7:0];
         CSR_PAYLOAD_LENGTH: hdr_length = data[7:0];
         CSR_MOVE_ACCEL: word_move_accel = data;
         CSR_ROTATE_ACCEL: word_rotate_accel = data;
         default: ;
      endcase
   endtask

   task automatic load_setup(input frame_setup_type s, input bit poke_spare);
      write_reg(CSR_START_BYTE, s.start_byte);
      write_reg(CSR_COMMAND_TYPE, s.command_type);
      write_reg(CSR_NODE_ID, s.node_id);
      write_reg(CSR_PAYLOAD_LENGTH, s.payload_length);
      write_reg(CSR_MOVE_ACCEL, s.move_accel);
      write_reg(CSR_ROTATE_ACCEL, s.rotate_accel);
      if (poke_spare) begin
         write_reg(CSR_SPARE_LO, $urandom());
         write_reg(CSR_SPARE_HI, $urandom());
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_payload_type random_command();
      req_payload_type cmd;
      cmd.speed_bits = pick_word();
      cmd.heading_bits = pick_word();
      cmd.turn_rate_bits = pick_word();
      return cmd;
   endfunction

   function automatic frame_setup_type random_setup();
      frame_setup_type s;
      s.start_byte = pick_word();
      s.command_type = pick_word();
      s.node_id = pick_word();
      s.payload_length = pick_word();
      s.move_accel = pick_word();
      s.rotate_accel = pick_word();
      return s;
   endfunction

   task automatic test_reset_defaults();
      send_command('0);
      send_command('1);
      drain_frames();
   endtask

   task automatic test_float_patterns();
      send_command({POS_INF, NEG_INF, QUIET_NAN});
      send_command({QUIET_NAN, POS_INF, NEG_ZERO});
      send_command({NEG_ZERO, QUIET_NAN, NEG_INF});
      send_command({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
      send_command({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
      drain_frames();
   endtask

   task automatic test_register_extremes();
      frame_setup_type s;
      load_setup('0, 1'b0);
      send_command('0);
      send_command(random_command());
      drain_frames();
      load_setup('1, 1'b0);
      send_command('1);
      send_command(random_command());
      drain_frames();
      // upper bits of the byte registers must be dropped, spare indexes ignored
      s = '{32'hFFFF_FF00, 32'hA5A5_A501, 32'h1234_56FE, 32'h8000_0014,
            32'h0000_0001, 32'h8000_0000};
      load_setup(s, 1'b1);
      send_command(random_command());
      send_command(random_command());
      drain_frames();
   endtask

   task automatic test_random_commands(input int count);
      int sent;
      int phase_len;
      sent = 0;
      while (sent < count) begin
         drain_frames();
         load_setup(random_setup(), $urandom_range(0, 1));
         source_idle_on = ($urandom_range(0, 2) != 0);
         sink_idle_on = ($urandom_range(0, 2) != 0);
         phase_len = $urandom_range(20, 40);
         for (int i = 0; i < phase_len && sent < count; i++) begin
            send_command(random_command());
            sent++;
            if ($urandom_range(0, 29) == 0) begin
               drain_frames();
            end
         end
      end
      drain_frames();
   endtask

   task automatic test_streaming(input int count);
      source_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      drain_frames();
      load_setup(random_setup(), 1'b0);
      for (int i = 0; i < count; i++) begin
         send_command(random_command());
      end
      drain_frames();
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frame_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("%0t: unexpected transaction byte %h offset %0d last %b", $time,
                        rsp_payload.frame_byte, rsp_payload.byte_offset, rsp_payload.last_byte);
            end
         end else begin
            due_byte = pending_frame_bytes.pop_front();
            if (rsp_payload.frame_byte !== due_byte.frame_byte ||
                rsp_payload.byte_offset !== due_byte.byte_offset ||
                rsp_payload.last_byte !== due_byte.last_byte) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("%0t: expected byte %h offset %0d last %b, got byte %h offset %0d last %b",
                           $time, due_byte.frame_byte, due_byte.byte_offset, due_byte.last_byte,
                           rsp_payload.frame_byte, rsp_payload.byte_offset,
                           rsp_payload.last_byte);
               end
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_float_patterns();
      test_register_extremes();
      test_random_commands(180);
      test_streaming(20);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/mcfc_pkg.sv
src/mcfc_ctrl.sv
src/mcfc_datapath.sv
src/motion_command_frame_crc16_top.sv
src/mcfc_checker.sv
bench/tb.sv
